// File: hdl/cpu8_pkg.sv
package cpu8_pkg;

    typedef enum logic [5:0] {
        OP_LDA, OP_LDX, OP_LDY, OP_STA, OP_STX, OP_STY, OP_TAX, OP_TAY, OP_TXA, OP_TYA,
        OP_TSX, OP_TXS, OP_PHA, OP_PHP, OP_PLA, OP_PLP, OP_AND, OP_EOR, OP_ORA, OP_BIT,
        OP_ADC, OP_SBC, OP_CMP, OP_CPX, OP_CPY, OP_INC, OP_INX, OP_INY, OP_DEC, OP_DEX,
        OP_DEY, OP_ASL_M, OP_ASL_A, OP_LSR_M, OP_LSR_A, OP_ROL_M, OP_ROL_A, OP_ROR_M,
        OP_ROR_A, OP_JMP, OP_JSR, OP_RTS, OP_BCC, OP_BCS, OP_BEQ, OP_BMI, OP_BNE, OP_BPL,
        OP_BVC, OP_BVS, OP_CLC, OP_CLD, OP_CLI, OP_CLV, OP_SEC, OP_SED, OP_SEI, OP_BRK,
        OP_NOP, OP_RTI
    } op_t;

    localparam int FL_C = 0;
    localparam int FL_Z = 1;
    localparam int FL_I = 2;
    localparam int FL_D = 3;
    localparam int FL_B = 4;
    localparam int FL_U = 5;
    localparam int FL_V = 6;
    localparam int FL_N = 7;

    localparam logic [7:0]  FLAGS_RESET  = 8'h24;
    localparam logic [7:0]  SP_RESET     = 8'hFF;
    localparam logic [7:0]  PUSH_BU      = 8'b0011_0000;
    localparam logic [7:0]  STACK_PAGE   = 8'h01;
    localparam int          MAX_WRITES   = 3;

    typedef struct packed {
        logic [5:0]  mode;
        logic [7:0]  operand;
        logic [15:0] effective_address;
        logic [15:0] next_pc;
        logic [7:0]  stack_byte_one;
        logic [7:0]  stack_byte_two;
        logic [7:0]  stack_byte_three;
    } item_t;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] sp;
        logic [7:0] flags;
    } regs_t;

    typedef struct packed {
        logic [1:0]                    cnt;
        logic [MAX_WRITES-1:0][15:0]   addr;
        logic [MAX_WRITES-1:0][7:0]    data;
        regs_t                         regs;
        logic [15:0]                   pc;
    } res_t;

endpackage

// File: hdl/cpu8_ifs.sv
interface cpu8_in_if;
    logic        valid;
    logic        ready;
    logic [5:0]  mode;
    logic [7:0]  operand;
    logic [15:0] effective_address;
    logic [15:0] next_pc;
    logic [7:0]  stack_byte_one;
    logic [7:0]  stack_byte_two;
    logic [7:0]  stack_byte_three;

    modport source (output valid, mode, operand, effective_address, next_pc,
                    stack_byte_one, stack_byte_two, stack_byte_three, input ready);
    modport sink (input valid, mode, operand, effective_address, next_pc,
                  stack_byte_one, stack_byte_two, stack_byte_three, output ready);
endinterface

interface cpu8_out_if;
    logic        valid;
    logic        ready;
    logic        write_enable;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic        last_result;
    logic [7:0]  accumulator_out;
    logic [7:0]  index_x_out;
    logic [7:0]  index_y_out;
    logic [7:0]  stack_pointer_out;
    logic [7:0]  flags_out;
    logic [15:0] new_pc;

    modport source (output valid, write_enable, write_address, write_data, last_result,
                    accumulator_out, index_x_out, index_y_out, stack_pointer_out,
                    flags_out, new_pc, input ready);
    modport sink (input valid, write_enable, write_address, write_data, last_result,
                  accumulator_out, index_x_out, index_y_out, stack_pointer_out,
                  flags_out, new_pc, output ready);
endinterface

// File: hdl/cpu8_alu.sv
module cpu8_alu
(
    input  cpu8_pkg::item_t item,
    input  cpu8_pkg::regs_t regs,
    output cpu8_pkg::res_t  res
);

    logic [7:0]  m;
    logic [7:0]  a;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  sp;
    logic [7:0]  f;
    logic [15:0] pc;
    logic [15:0] ret;
    logic        take;
    logic        nz_en;
    logic [7:0]  nz_val;
    logic [8:0]  sum;
    logic [7:0]  addend;
    logic [7:0]  cmp_src;
    logic [8:0]  diff;
    logic [7:0]  sh_src;
    logic [7:0]  sh_res;
    logic        sh_cout;
    logic        cin;

    assign m       = item.operand;
    assign cin     = regs.flags[cpu8_pkg::FL_C];
    assign addend  = (cpu8_pkg::op_t'(item.mode) == cpu8_pkg::OP_SBC) ? ~m : m;
    assign sum     = {1'b0, regs.a} + {1'b0, addend} + {8'd0, cin};
    assign ret     = item.next_pc - 16'd1;

    always_comb
    begin
        case (cpu8_pkg::op_t'(item.mode))
            cpu8_pkg::OP_CPX: cmp_src = regs.x;
            cpu8_pkg::OP_CPY: cmp_src = regs.y;
            default:          cmp_src = regs.a;
        endcase
    end
    assign diff = {1'b0, cmp_src} - {1'b0, m};

    always_comb
    begin
        sh_src  = m;
        sh_res  = {m[6:0], 1'b0};
        sh_cout = m[7];
        case (cpu8_pkg::op_t'(item.mode))
            cpu8_pkg::OP_ASL_A, cpu8_pkg::OP_LSR_A, cpu8_pkg::OP_ROL_A,
            cpu8_pkg::OP_ROR_A: sh_src = regs.a;
            default:            sh_src = m;
        endcase
        case (cpu8_pkg::op_t'(item.mode))
            cpu8_pkg::OP_LSR_M, cpu8_pkg::OP_LSR_A:
            begin
                sh_res  = {1'b0, sh_src[7:1]};
                sh_cout = sh_src[0];
            end
            cpu8_pkg::OP_ROL_M, cpu8_pkg::OP_ROL_A:
            begin
                sh_res  = {sh_src[6:0], cin};
                sh_cout = sh_src[7];
            end
            cpu8_pkg::OP_ROR_M, cpu8_pkg::OP_ROR_A:
            begin
                sh_res  = {cin, sh_src[7:1]};
                sh_cout = sh_src[0];
            end
            default:
            begin
                sh_res  = {sh_src[6:0], 1'b0};
                sh_cout = sh_src[7];
            end
        endcase
    end

    always_comb
    begin
        a      = regs.a;
        x      = regs.x;
        y      = regs.y;
        sp     = regs.sp;
        f      = regs.flags;
        pc     = item.next_pc;
        take   = 1'b0;
        nz_en  = 1'b0;
        nz_val = 8'd0;
        res.cnt  = 2'd0;
        res.addr = '0;
        res.data = '0;
        case (cpu8_pkg::op_t'(item.mode))
            cpu8_pkg::OP_LDA: begin a = m; nz_en = 1'b1; nz_val = m; end
            cpu8_pkg::OP_LDX: begin x = m; nz_en = 1'b1; nz_val = m; end
            cpu8_pkg::OP_LDY: begin y = m; nz_en = 1'b1; nz_val = m; end
            cpu8_pkg::OP_STA:
            begin
                res.cnt = 2'd1; res.addr[0] = item.effective_address; res.data[0] = regs.a;
            end
            cpu8_pkg::OP_STX:
            begin
                res.cnt = 2'd1; res.addr[0] = item.effective_address; res.data[0] = regs.x;
            end
            cpu8_pkg::OP_STY:
            begin
                res.cnt = 2'd1; res.addr[0] = item.effective_address; res.data[0] = regs.y;
            end
            cpu8_pkg::OP_TAX: begin x = regs.a; nz_en = 1'b1; nz_val = regs.a; end
            cpu8_pkg::OP_TAY: begin y = regs.a; nz_en = 1'b1; nz_val = regs.a; end
            cpu8_pkg::OP_TXA: begin a = regs.x; nz_en = 1'b1; nz_val = regs.x; end
            cpu8_pkg::OP_TYA: begin a = regs.y; nz_en = 1'b1; nz_val = regs.y; end
            cpu8_pkg::OP_TSX: begin x = regs.sp; nz_en = 1'b1; nz_val = regs.sp; end
            cpu8_pkg::OP_TXS: sp = regs.x;
            cpu8_pkg::OP_PHA:
            begin
                res.cnt = 2'd1;
                res.addr[0] = {cpu8_pkg::STACK_PAGE, regs.sp};
                res.data[0] = regs.a;
                sp = regs.sp - 8'd1;
            end
            cpu8_pkg::OP_PHP:
            begin
                res.cnt = 2'd1;
                res.addr[0] = {cpu8_pkg::STACK_PAGE, regs.sp};
                res.data[0] = regs.flags | cpu8_pkg::PUSH_BU;
                sp = regs.sp - 8'd1;
            end
            cpu8_pkg::OP_PLA:
            begin
                sp = regs.sp + 8'd1; a = item.stack_byte_one;
                nz_en = 1'b1; nz_val = item.stack_byte_one;
            end
            cpu8_pkg::OP_PLP:
            begin
                sp = regs.sp + 8'd1;
                f = item.stack_byte_one;
                f[cpu8_pkg::FL_B] = 1'b0;
                f[cpu8_pkg::FL_U] = 1'b1;
            end
            cpu8_pkg::OP_AND: begin a = regs.a & m; nz_en = 1'b1; nz_val = regs.a & m; end
            cpu8_pkg::OP_EOR: begin a = regs.a ^ m; nz_en = 1'b1; nz_val = regs.a ^ m; end
            cpu8_pkg::OP_ORA: begin a = regs.a | m; nz_en = 1'b1; nz_val = regs.a | m; end
            cpu8_pkg::OP_BIT:
            begin
                f[cpu8_pkg::FL_Z] = ((regs.a & m) == 8'd0);
                f[cpu8_pkg::FL_V] = m[6];
                f[cpu8_pkg::FL_N] = m[7];
            end
            cpu8_pkg::OP_ADC, cpu8_pkg::OP_SBC:
            begin
                a = sum[7:0];
                f[cpu8_pkg::FL_C] = sum[8];
                f[cpu8_pkg::FL_V] = ~(regs.a[7] ^ addend[7]) & (regs.a[7] ^ sum[7]);
                nz_en = 1'b1; nz_val = sum[7:0];
            end
            cpu8_pkg::OP_CMP, cpu8_pkg::OP_CPX, cpu8_pkg::OP_CPY:
            begin
                f[cpu8_pkg::FL_C] = ~diff[8];
                nz_en = 1'b1; nz_val = diff[7:0];
            end
            cpu8_pkg::OP_INC:
            begin
                res.cnt = 2'd1; res.addr[0] = item.effective_address;
                res.data[0] = m + 8'd1;
                nz_en = 1'b1; nz_val = m + 8'd1;
            end
            cpu8_pkg::OP_DEC:
            begin
                res.cnt = 2'd1; res.addr[0] = item.effective_address;
                res.data[0] = m - 8'd1;
                nz_en = 1'b1; nz_val = m - 8'd1;
            end
            cpu8_pkg::OP_INX: begin x = regs.x + 8'd1; nz_en = 1'b1; nz_val = regs.x + 8'd1; end
            cpu8_pkg::OP_INY: begin y = regs.y + 8'd1; nz_en = 1'b1; nz_val = regs.y + 8'd1; end
            cpu8_pkg::OP_DEX: begin x = regs.x - 8'd1; nz_en = 1'b1; nz_val = regs.x - 8'd1; end
            cpu8_pkg::OP_DEY: begin y = regs.y - 8'd1; nz_en = 1'b1; nz_val = regs.y - 8'd1; end
            cpu8_pkg::OP_ASL_M, cpu8_pkg::OP_LSR_M, cpu8_pkg::OP_ROL_M, cpu8_pkg::OP_ROR_M:
            begin
                res.cnt = 2'd1; res.addr[0] = item.effective_address; res.data[0] = sh_res;
                f[cpu8_pkg::FL_C] = sh_cout;
                nz_en = 1'b1; nz_val = sh_res;
            end
            cpu8_pkg::OP_ASL_A, cpu8_pkg::OP_LSR_A, cpu8_pkg::OP_ROL_A, cpu8_pkg::OP_ROR_A:
            begin
                a = sh_res;
                f[cpu8_pkg::FL_C] = sh_cout;
                nz_en = 1'b1; nz_val = sh_res;
            end
            cpu8_pkg::OP_JMP: pc = item.effective_address;
            cpu8_pkg::OP_JSR:
            begin
                res.cnt = 2'd2;
                res.addr[0] = {cpu8_pkg::STACK_PAGE, regs.sp};
                res.data[0] = ret[15:8];
                res.addr[1] = {cpu8_pkg::STACK_PAGE, regs.sp - 8'd1};
                res.data[1] = ret[7:0];
                sp = regs.sp - 8'd2;
                pc = item.effective_address;
            end
            cpu8_pkg::OP_RTS:
            begin
                sp = regs.sp + 8'd2;
                pc = {item.stack_byte_two, item.stack_byte_one} + 16'd1;
            end
            cpu8_pkg::OP_BCC: take = ~regs.flags[cpu8_pkg::FL_C];
            cpu8_pkg::OP_BCS: take = regs.flags[cpu8_pkg::FL_C];
            cpu8_pkg::OP_BEQ: take = regs.flags[cpu8_pkg::FL_Z];
            cpu8_pkg::OP_BMI: take = regs.flags[cpu8_pkg::FL_N];
            cpu8_pkg::OP_BNE: take = ~regs.flags[cpu8_pkg::FL_Z];
            cpu8_pkg::OP_BPL: take = ~regs.flags[cpu8_pkg::FL_N];
            cpu8_pkg::OP_BVC: take = ~regs.flags[cpu8_pkg::FL_V];
            cpu8_pkg::OP_BVS: take = regs.flags[cpu8_pkg::FL_V];
            cpu8_pkg::OP_CLC: f[cpu8_pkg::FL_C] = 1'b0;
            cpu8_pkg::OP_CLD: f[cpu8_pkg::FL_D] = 1'b0;
            cpu8_pkg::OP_CLI: f[cpu8_pkg::FL_I] = 1'b0;
            cpu8_pkg::OP_CLV: f[cpu8_pkg::FL_V] = 1'b0;
            cpu8_pkg::OP_SEC: f[cpu8_pkg::FL_C] = 1'b1;
            cpu8_pkg::OP_SED: f[cpu8_pkg::FL_D] = 1'b1;
            cpu8_pkg::OP_SEI: f[cpu8_pkg::FL_I] = 1'b1;
            cpu8_pkg::OP_BRK:
            begin
                res.cnt = 2'd3;
                res.addr[0] = {cpu8_pkg::STACK_PAGE, regs.sp};
                res.data[0] = item.next_pc[15:8];
                res.addr[1] = {cpu8_pkg::STACK_PAGE, regs.sp - 8'd1};
                res.data[1] = item.next_pc[7:0];
                res.addr[2] = {cpu8_pkg::STACK_PAGE, regs.sp - 8'd2};
                res.data[2] = regs.flags | cpu8_pkg::PUSH_BU;
                sp = regs.sp - 8'd3;
                f[cpu8_pkg::FL_I] = 1'b1;
                pc = item.effective_address;
            end
            cpu8_pkg::OP_RTI:
            begin
                sp = regs.sp + 8'd3;
                f = item.stack_byte_one;
                f[cpu8_pkg::FL_B] = 1'b0;
                f[cpu8_pkg::FL_U] = 1'b1;
                pc = {item.stack_byte_three, item.stack_byte_two};
            end
            default: ;
        endcase
        if (nz_en)
        begin
            f[cpu8_pkg::FL_Z] = (nz_val == 8'd0);
            f[cpu8_pkg::FL_N] = nz_val[7];
        end
        if (take)
        begin
            pc = item.next_pc + {{8{m[7]}}, m};
        end
        res.regs.a     = a;
        res.regs.x     = x;
        res.regs.y     = y;
        res.regs.sp    = sp;
        res.regs.flags = f;
        res.pc         = pc;
    end

endmodule

// File: hdl/cpu8_result_buf.sv
module cpu8_result_buf
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  cpu8_pkg::res_t    load_res,
    output logic              free,
    cpu8_out_if.source        res_ch
);

    logic           valid_reg;
    logic           valid_next;
    logic [1:0]     idx_reg;
    logic [1:0]     idx_next;
    cpu8_pkg::res_t res_reg;
    logic           last;
    logic           has_wr;

    assign has_wr = (res_reg.cnt != 2'd0);
    assign last   = has_wr ? (idx_reg == res_reg.cnt - 2'd1) : 1'b1;
    assign free   = ~valid_reg | (res_ch.ready & last);

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = 2'd0;
        end
        else if (valid_reg && res_ch.ready)
        begin
            if (last)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= load_res;
        end
    end

    assign res_ch.valid             = valid_reg;
    assign res_ch.write_enable      = has_wr;
    assign res_ch.write_address     = has_wr ? res_reg.addr[idx_reg] : 16'd0;
    assign res_ch.write_data        = has_wr ? res_reg.data[idx_reg] : 8'd0;
    assign res_ch.last_result       = last;
    assign res_ch.accumulator_out   = res_reg.regs.a;
    assign res_ch.index_x_out       = res_reg.regs.x;
    assign res_ch.index_y_out       = res_reg.regs.y;
    assign res_ch.stack_pointer_out = res_reg.regs.sp;
    assign res_ch.flags_out         = res_reg.regs.flags;
    assign res_ch.new_pc            = res_reg.pc;

endmodule

// File: hdl/cpu8_execute_unit_top.sv
// cpu_8bit_execute_unit: execute stage of a small 8-bit processor.
//
// cmd carries one decoded operation per item with its operand, effective
// address, following PC and the three stack bytes above SP. res carries the
// results: one item for an operation without memory writes, otherwise one
// item per write in bus order (up to three, for BRK). Every result item
// shows A, X, Y, SP, status and the next PC as they stand after the
// operation; last_result marks the final item of an operation.
//
// An item is latched into an input register, executed combinationally into
// a result register, and shown on res straight from that register. One
// operation enters per cycle while each leaves one result and res does not
// stall; an operation with n writes holds the result register until all n
// of its items are taken, which sets the rate.
//
// Reset clears A, X, Y, loads SP with 0xFF and status with 0x24, and empties
// both registers. When res stalls, the result register holds, the input
// register fills, and cmd.ready drops.
module cpu_8bit_execute_unit
(
    input  logic        clk,
    input  logic        rst_n,
    cpu8_in_if.sink     cmd,
    cpu8_out_if.source  res
);

    logic            in_valid_reg;
    logic            in_valid_next;
    cpu8_pkg::item_t in_reg;
    cpu8_pkg::regs_t regs_reg;
    cpu8_pkg::res_t  alu_res;
    logic            out_free;
    logic            exec;
    logic            take_in;

    assign exec     = in_valid_reg & out_free;
    assign cmd.ready = ~in_valid_reg | out_free;
    assign take_in  = cmd.valid & cmd.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take_in)
        begin
            in_valid_next = 1'b1;
        end
        else if (exec)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            regs_reg.a     <= 8'd0;
            regs_reg.x     <= 8'd0;
            regs_reg.y     <= 8'd0;
            regs_reg.sp    <= cpu8_pkg::SP_RESET;
            regs_reg.flags <= cpu8_pkg::FLAGS_RESET;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (exec)
            begin
                regs_reg <= alu_res.regs;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_reg.mode              <= cmd.mode;
            in_reg.operand           <= cmd.operand;
            in_reg.effective_address <= cmd.effective_address;
            in_reg.next_pc           <= cmd.next_pc;
            in_reg.stack_byte_one    <= cmd.stack_byte_one;
            in_reg.stack_byte_two    <= cmd.stack_byte_two;
            in_reg.stack_byte_three  <= cmd.stack_byte_three;
        end
    end

    cpu8_alu u_alu
    (
        .item (in_reg),
        .regs (regs_reg),
        .res  (alu_res)
    );

    cpu8_result_buf u_res
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (exec),
        .load_res (alu_res),
        .free     (out_free),
        .res_ch   (res)
    );

    a_nowr_last: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.write_enable |-> res.last_result)
        else $error("result without write not last");

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !exec |=> in_valid_reg)
        else $error("pending item lost");

    a_flag_u: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> res.flags_out[cpu8_pkg::FL_U])
        else $error("status bit five clear");

    a_no_exec_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.ready |-> !exec)
        else $error("result overwritten while stalled");

endmodule
